@@ design/rfp_pkg.sv @@
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants for the rarest-first piece picker.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam int MaxPieces = 1024;
    localparam int MaxPeers  = 16;
    localparam int PieceW    = 10;
    localparam int PeerW     = 4;
    localparam int CntW      = 11;
    // entry: avail[15:0], holders[20:16], status[22:21], retries[26:23]
    localparam int EntryW    = 27;

    localparam logic [3:0]  RetryLimitReset = 4'd8;
    localparam logic [31:0] StallTicksReset = 32'd30000;

    typedef enum logic [2:0] {
        K_BEGIN = 3'd0,
        K_AVAIL = 3'd1,
        K_REQ   = 3'd2,
        K_OK    = 3'd3,
        K_FAIL  = 3'd4,
        K_TICK  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_INFLIGHT = 2'd1,
        ST_DONE     = 2'd2
    } pstat_t;

    typedef enum logic [1:0] {
        REG_PIECE_COUNT = 2'd0,
        REG_RETRY_LIMIT = 2'd1,
        REG_STALL_TICKS = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD,
        S_WAIT,
        S_UPD,
        S_SCAN_RD,
        S_SCAN,
        S_GRANT,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch input item
        logic do_begin;   // latch count, reset counters
        logic clr_start;
        logic clr_step;
        logic rd_item;    // read entry of item piece
        logic upd;        // apply avail/ok/fail update
        logic tick;
        logic scan_start;
        logic scan_step;
        logic grant_wr;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        kind_t kind;
        logic  clr_last;
        logic  scan_last;
        logic  scan_empty;
        logic  out_busy;
    } stat_t;

endpackage

@@ design/rfp_ram.sv @@
// ----------------------------------------------------------------------------
// rfp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rfp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ design/rfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfp_ctrl
// Sequencer for item handling: clear sweep, read-modify-write, request scan.
// ----------------------------------------------------------------------------
module rfp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    output logic           in_ready,
    input  rfp_pkg::stat_t st,
    output rfp_pkg::cmd_t  cmd
);

    rfp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            rfp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = rfp_pkg::S_RD;
                end
            end
            rfp_pkg::S_RD:
            begin
                case (st.kind)
                    rfp_pkg::K_BEGIN:
                    begin
                        cmd.do_begin  = 1'b1;
                        cmd.clr_start = 1'b1;
                        state_next = rfp_pkg::S_CLEAR;
                    end
                    rfp_pkg::K_AVAIL, rfp_pkg::K_OK, rfp_pkg::K_FAIL:
                    begin
                        cmd.rd_item = 1'b1;
                        state_next = rfp_pkg::S_WAIT;
                    end
                    rfp_pkg::K_REQ:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = st.scan_empty ? rfp_pkg::S_GRANT
                                                   : rfp_pkg::S_SCAN_RD;
                    end
                    rfp_pkg::K_TICK:
                    begin
                        cmd.tick = 1'b1;
                        state_next = rfp_pkg::S_OUT;
                    end
                    default:
                    begin
                        state_next = rfp_pkg::S_OUT;
                    end
                endcase
            end
            rfp_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = rfp_pkg::S_OUT;
                end
            end
            rfp_pkg::S_WAIT:
            begin
                state_next = rfp_pkg::S_UPD;
            end
            rfp_pkg::S_UPD:
            begin
                cmd.upd = 1'b1;
                state_next = rfp_pkg::S_OUT;
            end
            rfp_pkg::S_SCAN_RD:
            begin
                // first read in flight
                cmd.scan_step = 1'b1;
                state_next = rfp_pkg::S_SCAN;
            end
            rfp_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    state_next = rfp_pkg::S_GRANT;
                end
            end
            rfp_pkg::S_GRANT:
            begin
                cmd.grant_wr = 1'b1;
                state_next = rfp_pkg::S_OUT;
            end
            rfp_pkg::S_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = rfp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rfp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ design/rfp_dp.sv @@
// ----------------------------------------------------------------------------
// rfp_dp
// Datapath: piece table RAM, scan comparator, counters and output register.
// ----------------------------------------------------------------------------
module rfp_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rfp_pkg::cmd_t                 cmd,
    output rfp_pkg::stat_t                st,
    input  logic [2:0]                    in_kind,
    input  logic [rfp_pkg::PeerW-1:0]     in_peer,
    input  logic [rfp_pkg::PieceW-1:0]    in_piece,
    input  logic                          in_has,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_idx,
    input  logic [31:0]                   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [23:0]                   out_data
);

    localparam int PW = rfp_pkg::PieceW;
    localparam int CW = rfp_pkg::CntW;
    localparam int EW = rfp_pkg::EntryW;

    logic [CW-1:0]  piece_count_reg;
    logic [3:0]     retry_limit_reg;
    logic [31:0]    stall_ticks_reg;
    logic [CW-1:0]  active_reg;
    logic [CW-1:0]  left_reg;
    logic [31:0]    idle_reg;
    logic           abort_reg;

    logic [2:0]     kind_reg;
    logic [3:0]     peer_reg;
    logic [PW-1:0]  piece_reg;
    logic           has_reg;

    logic [CW-1:0]  idx_reg;     // sweep / scan address counter
    logic [CW-1:0]  cmp_reg;     // index of entry now on rdata
    logic           found_reg;
    logic [PW-1:0]  best_reg;
    logic [4:0]     bestcnt_reg;
    // copy of the winning entry, written back as inflight on grant
    logic [EW-1:0]  bestent_reg;
    // rdata is valid on a scan step once the previous cycle issued a read
    logic           cmp_vld_reg;
    logic           scan_ok_reg;

    logic           ov_reg;
    logic [23:0]    od_reg;
    logic           granted_reg;

    logic           we;
    logic [PW-1:0]  addr;
    logic [EW-1:0]  wdata, rdata;

    rfp_ram #(.Width(EW), .Depth(rfp_pkg::MaxPieces)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    logic [15:0] r_av;
    logic [4:0]  r_hold;
    logic [1:0]  r_st;
    logic [3:0]  r_ret;
    assign r_av   = rdata[15:0];
    assign r_hold = rdata[20:16];
    assign r_st   = rdata[22:21];
    assign r_ret  = rdata[26:23];

    logic        piece_ok;
    logic        cur;
    logic [4:0]  nret;
    logic        cand;
    assign piece_ok = {1'b0, piece_reg} < active_reg;
    assign cur      = r_av[peer_reg];
    assign nret     = {1'b0, r_ret} + 5'd1;
    assign cand     = scan_ok_reg && (r_st == rfp_pkg::ST_PENDING) && r_av[peer_reg]
                      && (!found_reg || r_hold < bestcnt_reg);

    // RAM port mux
    always_comb
    begin
        we    = 1'b0;
        addr  = piece_reg;
        wdata = rdata;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            addr  = idx_reg[PW-1:0];
            wdata = '0;
        end
        else if (cmd.scan_step)
        begin
            addr = idx_reg[PW-1:0];
        end
        else if (cmd.grant_wr)
        begin
            addr = best_reg;
            we   = found_reg;
            wdata = {bestent_reg[26:23], rfp_pkg::ST_INFLIGHT, bestent_reg[20:0]};
        end
        else if (cmd.grant_wr == 1'b0 && cmd.upd && piece_ok)
        begin
            unique case (kind_reg)
                rfp_pkg::K_AVAIL:
                begin
                    if (has_reg && !cur)
                    begin
                        we = 1'b1;
                        wdata = {r_ret, r_st, r_hold + 5'd1, r_av | (16'd1 << peer_reg)};
                    end
                    else if (!has_reg && cur)
                    begin
                        we = 1'b1;
                        wdata = {r_ret, r_st, r_hold - 5'd1, r_av & ~(16'd1 << peer_reg)};
                    end
                end
                rfp_pkg::K_OK:
                begin
                    we = (r_st != rfp_pkg::ST_DONE);
                    wdata = {r_ret, rfp_pkg::ST_DONE, r_hold, r_av};
                end
                rfp_pkg::K_FAIL:
                begin
                    we = (r_st != rfp_pkg::ST_DONE);
                    wdata = {(nret > 5'd15) ? 4'd15 : nret[3:0],
                             rfp_pkg::ST_PENDING, r_hold, r_av};
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_count_reg <= '0;
            retry_limit_reg <= rfp_pkg::RetryLimitReset;
            stall_ticks_reg <= rfp_pkg::StallTicksReset;
            active_reg  <= '0;
            left_reg    <= '0;
            idle_reg    <= '0;
            abort_reg   <= 1'b0;
            ov_reg      <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    rfp_pkg::REG_PIECE_COUNT: piece_count_reg <= cfg_data[CW-1:0];
                    rfp_pkg::REG_RETRY_LIMIT: retry_limit_reg <= cfg_data[3:0];
                    rfp_pkg::REG_STALL_TICKS: stall_ticks_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.do_begin)
            begin
                active_reg <= (piece_count_reg > CW'(rfp_pkg::MaxPieces))
                              ? CW'(rfp_pkg::MaxPieces) : piece_count_reg;
                left_reg   <= (piece_count_reg > CW'(rfp_pkg::MaxPieces))
                              ? CW'(rfp_pkg::MaxPieces) : piece_count_reg;
                idle_reg   <= '0;
                abort_reg  <= 1'b0;
            end
            if (cmd.tick && idle_reg != '1)
            begin
                idle_reg <= idle_reg + 32'd1;
            end
            if (cmd.upd && piece_ok && r_st != rfp_pkg::ST_DONE)
            begin
                if (kind_reg == rfp_pkg::K_OK)
                begin
                    if (left_reg != '0)
                    begin
                        left_reg <= left_reg - CW'(1);
                    end
                    idle_reg <= '0;
                end
                if (kind_reg == rfp_pkg::K_FAIL && nret > {1'b0, retry_limit_reg})
                begin
                    abort_reg <= 1'b1;
                end
            end
            if (cmd.scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step && cmp_vld_reg && cand)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.grant_wr && !found_reg && scan_ok_reg && idle_reg > stall_ticks_reg)
            begin
                abort_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan_step && (idx_reg < active_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            peer_reg  <= in_peer;
            piece_reg <= in_piece;
            has_reg   <= in_has;
            granted_reg <= 1'b0;
        end
        if (cmd.clr_start || cmd.scan_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.clr_step || cmd.scan_step)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
        cmp_reg <= idx_reg;
        if (cmd.scan_start)
        begin
            scan_ok_reg <= !abort_reg && left_reg != '0;
        end
        if (cmd.scan_step && cmp_vld_reg && cand)
        begin
            best_reg    <= cmp_reg[PW-1:0];
            bestcnt_reg <= r_hold;
            bestent_reg <= rdata;
        end
        if (cmd.grant_wr)
        begin
            granted_reg <= found_reg;
        end
        if (cmd.out_load)
        begin
            od_reg <= {left_reg, (left_reg == '0), abort_reg,
                       granted_reg ? best_reg : {PW{1'b0}}, granted_reg};
        end
    end

    // the scan is gated with scan_ok: when blocked, the scan just finds nothing
    assign st.kind       = rfp_pkg::kind_t'(kind_reg);
    assign st.clr_last   = idx_reg == CW'(rfp_pkg::MaxPieces - 1);
    assign st.scan_last  = idx_reg >= active_reg;
    assign st.scan_empty = 1'b0;
    assign st.out_busy   = ov_reg;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

@@ design/rarest_first_piece_picker.sv @@
// ----------------------------------------------------------------------------
// rarest_first_piece_picker
// Rarest-first piece scheduler: availability table, request scan, retries.
// ----------------------------------------------------------------------------
// Processing: begin runs a clearing sweep over all 1024 entries; a request
// scans the table with one table read per piece. One item at a time: the
// next transfer is taken the cycle after the result is loaded.
// Reset: asynchronous, active low; registers to defaults, table undefined
// until the first begin item clears it.
module rarest_first_piece_picker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // kind
    input  logic [15:0] s_axis_tdata,   // peer[3:0], piece[13:4], has[14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // granted, chosen_piece[10:1], aborted,
                                        // finished, remaining[23:13]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    rfp_pkg::cmd_t  cmd;
    rfp_pkg::stat_t st;
    logic           in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    rfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rfp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_kind   (s_axis_tuser),
        .in_peer   (s_axis_tdata[3:0]),
        .in_piece  (s_axis_tdata[13:4]),
        .in_has    (s_axis_tdata[14]),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_addr),
        .cfg_data  (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ bench/rarest_first_piece_picker_tb.sv @@
// ----------------------------------------------------------------------------
// rarest_first_piece_picker_tb
// Self-checking bench for the piece picker. Items go in on the slave stream,
// a predictor of the table follows every accepted transfer, and each result
// transfer is compared field by field with the oldest prediction. Directed
// corner cases come first, then sessions of random traffic over several
// settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rarest_first_piece_picker_tb;

    localparam logic [2:0] K_SPARE_A = 3'd6;
    localparam logic [2:0] K_SPARE_B = 3'd7;
    localparam int         StallLimit = 30000;

    typedef struct packed {
        logic       granted;
        logic [9:0] chosen;
        logic       aborted;
        logic       finished;
        logic [10:0] remaining;
    } pick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    rarest_first_piece_picker dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [15:0]      avail_map [rfp_pkg::MaxPieces];
    logic [4:0]       holders   [rfp_pkg::MaxPieces];
    rfp_pkg::pstat_t  status    [rfp_pkg::MaxPieces];
    logic [3:0]       retries   [rfp_pkg::MaxPieces];
    logic [10:0] pieces_left;
    logic [31:0] idle_ticks;
    logic        abort_flag;
    logic [10:0] active_count;
    logic [10:0] piece_count_reg;
    logic [3:0]  retry_limit_reg;
    logic [31:0] stall_ticks_reg;

    pick_t pending_picks [$];
    int    inflight_pieces [$];
    int    fails = 0;
    int    items_sent = 0;
    int    grants_seen = 0;
    int    aborts_seen = 0;
    int    sender_gap_pct = 0;
    int    stall_pct = 0;
    int    quiet_cycles = 0;

    function automatic pick_t predict_picker(logic [2:0] kind, logic [3:0] peer,
                                             logic [9:0] piece, logic has);
        pick_t      r;
        logic       in_range;
        logic [4:0] best;
        logic [4:0] tries;
        r = '0;
        best = '0;
        in_range = piece < active_count;
        case (kind)
            rfp_pkg::K_BEGIN:
            begin
                for (int i = 0; i < rfp_pkg::MaxPieces; i++)
                begin
                    avail_map[i] = '0;
                    holders[i] = '0;
                    status[i] = rfp_pkg::ST_PENDING;
                    retries[i] = '0;
                end
                idle_ticks = '0;
                abort_flag = 1'b0;
                active_count = (piece_count_reg > rfp_pkg::MaxPieces)
                               ? 11'(rfp_pkg::MaxPieces) : piece_count_reg;
                pieces_left = active_count;
                inflight_pieces.delete();
            end
            rfp_pkg::K_AVAIL:
            begin
                if (in_range && has && !avail_map[piece][peer])
                begin
                    avail_map[piece][peer] = 1'b1;
                    holders[piece]++;
                end
                else if (in_range && !has && avail_map[piece][peer])
                begin
                    avail_map[piece][peer] = 1'b0;
                    holders[piece]--;
                end
            end
            rfp_pkg::K_REQ:
            begin
                if (!abort_flag && pieces_left != 0)
                begin
                    for (int i = 0; i < active_count; i++)
                        if (status[i] == rfp_pkg::ST_PENDING && avail_map[i][peer] &&
                            (!r.granted || holders[i] < best))
                        begin
                            r.granted = 1'b1;
                            r.chosen = 10'(i);
                            best = holders[i];
                        end
                    if (r.granted)
                    begin
                        status[r.chosen] = rfp_pkg::ST_INFLIGHT;
                        inflight_pieces = {inflight_pieces, int'(r.chosen)};
                    end
                    else if (idle_ticks > stall_ticks_reg)
                        abort_flag = 1'b1;
                end
            end
            rfp_pkg::K_OK:
            begin
                if (in_range && status[piece] != rfp_pkg::ST_DONE)
                begin
                    status[piece] = rfp_pkg::ST_DONE;
                    if (pieces_left != 0)
                        pieces_left--;
                    idle_ticks = '0;
                end
            end
            rfp_pkg::K_FAIL:
            begin
                if (in_range && status[piece] != rfp_pkg::ST_DONE)
                begin
                    tries = retries[piece] + 5'd1;
                    status[piece] = rfp_pkg::ST_PENDING;
                    if (tries > retry_limit_reg)
                        abort_flag = 1'b1;
                    retries[piece] = (tries > 5'd15) ? 4'd15 : tries[3:0];
                end
            end
            rfp_pkg::K_TICK:
            begin
                if (idle_ticks != '1)
                    idle_ticks++;
            end
            default: ;
        endcase
        r.aborted = abort_flag;
        r.finished = (pieces_left == 0);
        r.remaining = pieces_left;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d (t=%0t)", field, got, want, $realtime);
        fails++;
    endtask

    // result checker; tdata: granted, chosen[10:1], aborted, finished, remaining[23:13]
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_picks.size() == 0)
                report_mismatch("unexpected transfer", 1, 0);
            else
            begin
                want = pending_picks.pop_front();
                if (m_axis_tdata[0] !== want.granted)
                    report_mismatch("granted", m_axis_tdata[0], want.granted);
                if (m_axis_tdata[10:1] !== want.chosen)
                    report_mismatch("chosen_piece", m_axis_tdata[10:1], want.chosen);
                if (m_axis_tdata[11] !== want.aborted)
                    report_mismatch("aborted", m_axis_tdata[11], want.aborted);
                if (m_axis_tdata[12] !== want.finished)
                    report_mismatch("finished", m_axis_tdata[12], want.finished);
                if (m_axis_tdata[23:13] !== want.remaining)
                    report_mismatch("remaining", m_axis_tdata[23:13], want.remaining);
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("watchdog expired with %0d results outstanding", pending_picks.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] kind, logic [3:0] peer, logic [9:0] piece, logic has);
        pick_t r;
        if ($urandom_range(99) < sender_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {1'b0, has, piece, peer};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_picker(kind, peer, piece, has);
        pending_picks = {pending_picks, r};
        items_sent++;
        grants_seen += r.granted;
    endtask

    // lowers valid and waits until every result is back and the block settles
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(rfp_pkg::reg_idx_t idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rfp_pkg::REG_PIECE_COUNT: piece_count_reg = value[10:0];
            rfp_pkg::REG_RETRY_LIMIT: retry_limit_reg = value[3:0];
            rfp_pkg::REG_STALL_TICKS: stall_ticks_reg = value;
            default: ;
        endcase
    endtask

    task automatic setup_download(logic [31:0] count, logic [31:0] limit, logic [31:0] stall);
        wait_idle();
        write_reg(rfp_pkg::REG_PIECE_COUNT, count);
        write_reg(rfp_pkg::REG_RETRY_LIMIT, limit);
        write_reg(rfp_pkg::REG_STALL_TICKS, stall);
        send_item(rfp_pkg::K_BEGIN, 4'd0, 10'd0, 1'b0);
    endtask

    task automatic test_full_table();
        // oversized count clamps; top piece and top peer, repeats ignored
        setup_download(32'd2047, 32'd15, 32'hFFFF_FFFF);
        send_item(rfp_pkg::K_AVAIL, 4'd15, 10'd1023, 1'b1);
        send_item(rfp_pkg::K_AVAIL, 4'd0, 10'd0, 1'b1);
        send_item(rfp_pkg::K_AVAIL, 4'd0, 10'd0, 1'b1);
        send_item(rfp_pkg::K_REQ, 4'd15, 10'd0, 1'b0);
        send_item(rfp_pkg::K_REQ, 4'd0, 10'd0, 1'b0);
        send_item(rfp_pkg::K_REQ, 4'd5, 10'd0, 1'b0);
        send_item(rfp_pkg::K_OK, 4'd0, 10'd1023, 1'b0);
        send_item(rfp_pkg::K_OK, 4'd0, 10'd1023, 1'b0);
        send_item(rfp_pkg::K_FAIL, 4'd0, 10'd1023, 1'b0);
        send_item(rfp_pkg::K_FAIL, 4'd0, 10'd0, 1'b0);
        send_item(K_SPARE_A, 4'd3, 10'd7, 1'b1);
        send_item(K_SPARE_B, 4'd3, 10'd7, 1'b1);
    endtask

    task automatic test_rarest_and_abort();
        setup_download(32'd6, 32'd0, 32'd1);
        send_item(rfp_pkg::K_AVAIL, 4'd1, 10'd3, 1'b1);
        send_item(rfp_pkg::K_AVAIL, 4'd2, 10'd3, 1'b1);
        send_item(rfp_pkg::K_AVAIL, 4'd1, 10'd5, 1'b1);
        send_item(rfp_pkg::K_AVAIL, 4'd1, 10'd4, 1'b1);
        send_item(rfp_pkg::K_AVAIL, 4'd2, 10'd3, 1'b0);
        send_item(rfp_pkg::K_AVAIL, 4'd1, 10'd9, 1'b1);
        send_item(rfp_pkg::K_REQ, 4'd1, 10'd0, 1'b0);
        send_item(rfp_pkg::K_OK, 4'd0, 10'd4, 1'b0);
        send_item(rfp_pkg::K_TICK, 4'd0, 10'd0, 1'b0);
        send_item(rfp_pkg::K_TICK, 4'd0, 10'd0, 1'b0);
        send_item(rfp_pkg::K_REQ, 4'd3, 10'd0, 1'b0);
        send_item(rfp_pkg::K_FAIL, 4'd0, 10'd3, 1'b0);
        send_item(rfp_pkg::K_REQ, 4'd1, 10'd0, 1'b0);
        // empty download: finished straight away
        setup_download(32'd0, 32'd8, 32'd30000);
        send_item(rfp_pkg::K_REQ, 4'd1, 10'd0, 1'b0);
    endtask

    task automatic run_session(int n, logic [31:0] count, logic [31:0] limit,
                               logic [31:0] stall, bit hold_off);
        int       sel;
        int       k;
        logic [9:0] pc;
        setup_download(count, limit, stall);
        for (int i = 0; i < n; i++)
        begin
            if (hold_off && i == n / 2)
                wait_idle();
            sel = $urandom_range(99);
            pc = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                          : 10'($urandom_range(count > 0 ? count - 1 : 0));
            if (sel < 28)
                send_item(rfp_pkg::K_AVAIL, 4'($urandom), pc, $urandom_range(3) != 0);
            else if (sel < 50)
                send_item(rfp_pkg::K_REQ, 4'($urandom), 10'($urandom), 1'($urandom));
            else if (sel < 82 && inflight_pieces.size() != 0)
            begin
                k = $urandom_range(inflight_pieces.size() - 1);
                pc = 10'(inflight_pieces[k]);
                inflight_pieces.delete(k);
                send_item(sel < 68 ? rfp_pkg::K_OK : rfp_pkg::K_FAIL, 4'($urandom), pc,
                          1'($urandom));
            end
            else if (sel < 92)
                send_item(rfp_pkg::K_TICK, 4'($urandom), 10'($urandom), 1'($urandom));
            else
                send_item(3'($urandom_range(1, 7)), 4'($urandom), pc, 1'($urandom));
        end
        aborts_seen += abort_flag;
    endtask

    task automatic test_random_traffic();
        int gap_mode [4] = '{0, 50, 0, 16};
        int stall_mode [4] = '{0, 0, 50, 16};
        for (int s = 0; s < 12; s++)
        begin
            wait_idle();
            sender_gap_pct = gap_mode[s / 3];
            stall_pct = stall_mode[s / 3];
            if (s == 5)
                run_session(20, 32'd1024, 32'd15, 32'hFFFF_FFFF, 1'b0);
            else
                run_session(48, $urandom_range(1, 40), $urandom_range(0, 15),
                            $urandom_range(1, 12), s == 7);
        end
    endtask

    initial
    begin
        int drain_wait;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        piece_count_reg = '0;
        retry_limit_reg = rfp_pkg::RetryLimitReset;
        stall_ticks_reg = rfp_pkg::StallTicksReset;
        active_count = '0;
        pieces_left = '0;
        idle_ticks = '0;
        abort_flag = 1'b0;
        @(posedge clk);
        test_full_table();
        test_rarest_and_abort();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_picks.size() != 0 && drain_wait < StallLimit)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (20) @(posedge clk);
        $display("%0d items sent, %0d grants predicted, %0d sessions ending aborted;",
                 items_sent, grants_seen, aborts_seen);
        $display("covered clamped and empty counts, rarest ties, retries, stalls, idling.");
        if (fails == 0 && pending_picks.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", fails, pending_picks.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
